@@ src/wprc_pkg.sv @@
// Package: widths, register codes, controller types and the rate class function.
package wprc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_SMOOTH  = 16;

    localparam int TIME_W    = 32;
    localparam int SMOOTH_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam int CNT_W   = $clog2(MAX_SMOOTH + 1);
    localparam int ACC_W   = SAMPLE_BITS + CNT_W;
    localparam int STEP_W  = $clog2(ACC_W);

    localparam logic [SAMPLE_BITS-1:0] THR_ON_RST  = SAMPLE_BITS'(2000);
    localparam logic [SAMPLE_BITS-1:0] THR_OFF_RST = SAMPLE_BITS'(1500);
    localparam logic [TIME_W-1:0]      WINDOW_RST  = TIME_W'(10000);
    localparam logic [TIME_W-1:0]      DEBOUNCE_RST = TIME_W'(200);
    localparam logic [SMOOTH_W-1:0]    SMOOTH_RST  = SMOOTH_W'(4);

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_ON   = 3'd0,
        CFG_THR_OFF  = 3'd1,
        CFG_WINDOW   = 3'd2,
        CFG_DEBOUNCE = 3'd3,
        CFG_SMOOTH   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_CALM        = 2'd0,
        CLS_REGULATING  = 2'd1,
        CLS_ACTIVE      = 2'd2,
        CLS_OVERWHELMED = 2'd3
    } t_rate_class;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_EVAL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic add;
        logic div_step;
        logic eval;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic grp_fire;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic t_rate_class class_of(input logic [COUNT_BITS-1:0] n);
        t_rate_class c;
        if (n <= COUNT_BITS'(1)) begin
            c = CLS_CALM;
        end else if (n == COUNT_BITS'(2)) begin
            c = CLS_REGULATING;
        end else if (n == COUNT_BITS'(3)) begin
            c = CLS_ACTIVE;
        end else begin
            c = CLS_OVERWHELMED;
        end
        return c;
    endfunction

endpackage

@@ src/wprc_if.sv @@
// Interfaces: sample input channel and result output channel.
interface wprc_in_if;
    logic                             valid;
    logic                             ready;
    logic [wprc_pkg::SAMPLE_BITS-1:0] sample;
    logic [wprc_pkg::TIME_W-1:0]      now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface wprc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             group_done;
    logic [wprc_pkg::SAMPLE_BITS-1:0] level;
    logic                             pressed;
    logic [wprc_pkg::COUNT_BITS-1:0]  press_count;
    logic                             window_closed;
    logic [wprc_pkg::COUNT_BITS-1:0]  window_total;
    logic [1:0]                       rate_class;

    modport source (output valid, output group_done, output level, output pressed,
                    output press_count, output window_closed, output window_total,
                    output rate_class, input ready);
    modport sink   (input valid, input group_done, input level, input pressed,
                    input press_count, input window_closed, input window_total,
                    input rate_class, output ready);
endinterface

@@ src/windowed_press_rate_classifier.sv @@
// Top level: windowed press-rate classifier, controller plus datapath.
//
// Each accepted sample beat yields exactly one result beat. A sample that does
// not complete an averaging group goes through accept, accumulate and emit; a
// sample that completes a group adds a divide and an evaluate step before the
// emit, because the group average comes from a bit-serial restoring divider
// that produces one quotient bit per cycle over the ACC_W-bit group sum,
// followed by the evaluation. The result sits in an output register, so
// the next sample is taken while it waits; emission stalls only if the
// previous result has still not been taken.
module windowed_press_rate_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wprc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wprc_pkg::CFG_W-1:0]       i_cfg_data,
    wprc_in_if.sink                          i_in,
    wprc_out_if.source                       o_out
);

    wprc_pkg::t_ctrl_cmd cmd;
    wprc_pkg::t_dp_sts   sts;
    wprc_pkg::t_state    state;
    logic                in_ready;

    wprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    wprc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_sample        (i_in.sample),
        .i_now_ms        (i_in.now_ms),
        .i_out_ready     (o_out.ready),
        .o_sts           (sts),
        .o_out_valid     (o_out.valid),
        .o_group_done    (o_out.group_done),
        .o_level         (o_out.level),
        .o_pressed       (o_out.pressed),
        .o_press_count   (o_out.press_count),
        .o_window_closed (o_out.window_closed),
        .o_window_total  (o_out.window_total),
        .o_rate_class    (o_out.rate_class)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (state == wprc_pkg::ST_ADD))
        else $error("accepted beat did not start accumulation");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.emit))
        else $error("result valid rose without an emit");

    a_no_close_without_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.group_done) |->
            (!o_out.window_closed && o_out.window_total == '0))
        else $error("window closed on a beat with no completed group");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.add, cmd.div_step, cmd.eval, cmd.emit}))
        else $error("controller issued overlapping commands");
`endif

endmodule

@@ src/wprc_ctrl.sv @@
// Controller: sequences accept, accumulate, divide, evaluate and emit.
module wprc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  wprc_pkg::t_dp_sts   i_sts,
    output logic                o_in_ready,
    output wprc_pkg::t_ctrl_cmd o_cmd,
    output wprc_pkg::t_state    o_state
);

    wprc_pkg::t_state r_state;
    wprc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wprc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wprc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = wprc_pkg::ST_ADD;
            end
            wprc_pkg::ST_ADD: begin
                n_state = i_sts.grp_fire ? wprc_pkg::ST_DIV : wprc_pkg::ST_EMIT;
            end
            wprc_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = wprc_pkg::ST_EVAL;
            end
            wprc_pkg::ST_EVAL: begin
                n_state = wprc_pkg::ST_EMIT;
            end
            wprc_pkg::ST_EMIT: begin
                if (i_sts.out_free) n_state = wprc_pkg::ST_IDLE;
            end
            default: begin
                n_state = wprc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            wprc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            wprc_pkg::ST_ADD:  o_cmd.add      = 1'b1;
            wprc_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            wprc_pkg::ST_EVAL: o_cmd.eval     = 1'b1;
            wprc_pkg::ST_EMIT: o_cmd.emit     = i_sts.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

@@ src/wprc_dp.sv @@
// Datapath: config registers, accumulator, serial divider, press/window logic, output register.
module wprc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wprc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wprc_pkg::CFG_W-1:0]       i_cfg_data,
    input  wprc_pkg::t_ctrl_cmd              i_cmd,
    input  logic [wprc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [wprc_pkg::TIME_W-1:0]      i_now_ms,
    input  logic                             i_out_ready,
    output wprc_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    output logic                             o_group_done,
    output logic [wprc_pkg::SAMPLE_BITS-1:0] o_level,
    output logic                             o_pressed,
    output logic [wprc_pkg::COUNT_BITS-1:0]  o_press_count,
    output logic                             o_window_closed,
    output logic [wprc_pkg::COUNT_BITS-1:0]  o_window_total,
    output logic [1:0]                       o_rate_class
);

    localparam int SB = wprc_pkg::SAMPLE_BITS;
    localparam int CB = wprc_pkg::COUNT_BITS;
    localparam int TW = wprc_pkg::TIME_W;
    localparam int NW = wprc_pkg::CNT_W;
    localparam int AW = wprc_pkg::ACC_W;
    localparam int SW = wprc_pkg::STEP_W;

    // configuration
    logic [SB-1:0]                 r_thr_on;
    logic [SB-1:0]                 r_thr_off;
    logic [TW-1:0]                 r_window;
    logic [TW-1:0]                 r_debounce;
    logic [wprc_pkg::SMOOTH_W-1:0] r_smooth;

    // block state
    logic [AW-1:0]         r_acc;
    logic [NW-1:0]         r_cnt;
    logic [SB-1:0]         r_level;
    logic                  r_held;
    logic [TW-1:0]         r_last_press;
    logic [TW-1:0]         r_win_start;
    logic [CB-1:0]         r_count;
    wprc_pkg::t_rate_class r_class;
    logic                  r_out_vld;

    // per-item payload
    logic [SB-1:0] r_sample;
    logic [TW-1:0] r_now;
    logic [AW-1:0] r_div_q;
    logic [NW-1:0] r_rem;
    logic [SW-1:0] r_step;
    logic          r_done;
    logic          r_closed;
    logic [CB-1:0] r_total;

    logic          r_o_done;
    logic [SB-1:0] r_o_level;
    logic          r_o_pressed;
    logic [CB-1:0] r_o_count;
    logic          r_o_closed;
    logic [CB-1:0] r_o_total;
    logic [1:0]    r_o_class;

    logic [NW-1:0] gsize;
    logic [AW-1:0] n_acc;
    logic [NW-1:0] n_cnt;
    logic          grp_fire;
    logic [NW:0]   rem_sh;
    logic          q_bit;
    logic [NW-1:0] n_rem;

    logic [SB-1:0]         ev_level;
    logic                  press_ok;
    logic                  held1;
    logic [CB-1:0]         count1;
    logic                  win_end;
    logic [TW-1:0]         dt_press;
    logic [TW-1:0]         dt_win;

    always_comb begin
        if (32'(r_smooth) > 32'(wprc_pkg::MAX_SMOOTH)) begin
            gsize = NW'(wprc_pkg::MAX_SMOOTH);
        end else if (r_smooth == '0) begin
            gsize = NW'(1);
        end else begin
            gsize = NW'(r_smooth);
        end
    end

    assign n_acc    = r_acc + AW'(r_sample);
    assign n_cnt    = r_cnt + NW'(1);
    assign grp_fire = (n_cnt >= gsize);

    // restoring divider step
    assign rem_sh = {r_rem, r_div_q[AW-1]};
    assign q_bit  = (rem_sh >= {1'b0, gsize});
    assign n_rem  = q_bit ? NW'(rem_sh - {1'b0, gsize}) : rem_sh[NW-1:0];

    // evaluation
    assign ev_level = r_div_q[SB-1:0];
    assign dt_press = r_now - r_last_press;
    assign dt_win   = r_now - r_win_start;
    assign press_ok = !r_held && (ev_level >= r_thr_on) && (dt_press > r_debounce);
    assign held1    = r_held || press_ok;
    assign count1   = (press_ok && r_count != wprc_pkg::COUNT_MAX) ? r_count + CB'(1)
                                                                   : r_count;
    assign win_end  = (dt_win >= r_window);

    assign o_sts.grp_fire = grp_fire;
    assign o_sts.div_last = (r_step == SW'(AW - 1));
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_on     <= wprc_pkg::THR_ON_RST;
            r_thr_off    <= wprc_pkg::THR_OFF_RST;
            r_window     <= wprc_pkg::WINDOW_RST;
            r_debounce   <= wprc_pkg::DEBOUNCE_RST;
            r_smooth     <= wprc_pkg::SMOOTH_RST;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_level      <= '0;
            r_held       <= 1'b0;
            r_last_press <= '0;
            r_win_start  <= '0;
            r_count      <= '0;
            r_class      <= wprc_pkg::CLS_CALM;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (wprc_pkg::t_cfg_idx'(i_cfg_idx))
                    wprc_pkg::CFG_THR_ON:   r_thr_on   <= i_cfg_data[SB-1:0];
                    wprc_pkg::CFG_THR_OFF:  r_thr_off  <= i_cfg_data[SB-1:0];
                    wprc_pkg::CFG_WINDOW:   r_window   <= i_cfg_data[TW-1:0];
                    wprc_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[TW-1:0];
                    wprc_pkg::CFG_SMOOTH:   r_smooth   <= i_cfg_data[wprc_pkg::SMOOTH_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.add) begin
                r_acc <= grp_fire ? '0 : n_acc;
                r_cnt <= grp_fire ? '0 : n_cnt;
            end
            if (i_cmd.eval) begin
                r_level <= ev_level;
                r_held  <= held1 && !(ev_level <= r_thr_off);
                if (press_ok) r_last_press <= r_now;
                if (win_end) begin
                    r_class     <= wprc_pkg::class_of(count1);
                    r_count     <= '0;
                    r_win_start <= r_now;
                end else begin
                    r_count <= count1;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_now    <= i_now_ms;
        end
        if (i_cmd.add) begin
            r_done   <= grp_fire;
            r_closed <= 1'b0;
            r_total  <= '0;
            r_div_q  <= n_acc;
            r_rem    <= '0;
            r_step   <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_q <= {r_div_q[AW-2:0], q_bit};
            r_rem   <= n_rem;
            r_step  <= r_step + SW'(1);
        end
        if (i_cmd.eval && win_end) begin
            r_closed <= 1'b1;
            r_total  <= count1;
        end
        if (i_cmd.emit) begin
            r_o_done    <= r_done;
            r_o_level   <= r_level;
            r_o_pressed <= r_held;
            r_o_count   <= r_count;
            r_o_closed  <= r_closed;
            r_o_total   <= r_total;
            r_o_class   <= r_class;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_group_done    = r_o_done;
    assign o_level         = r_o_level;
    assign o_pressed       = r_o_pressed;
    assign o_press_count   = r_o_count;
    assign o_window_closed = r_o_closed;
    assign o_window_total  = r_o_total;
    assign o_rate_class    = r_o_class;

endmodule
